### rtl/core/gbcm_pkg.sv
// Shared constants, types and codes for the grid bilinear coordinate map.
// Used by every module of the block but gbcm_ram; depends on nothing else.
package gbcm_pkg;

  localparam int MAX_COLUMNS = 256;
  localparam int MAX_ROWS    = 256;

  // Cell index widths and widths that can hold the grid size itself.
  localparam int CB  = $clog2(MAX_COLUMNS);
  localparam int RB  = $clog2(MAX_ROWS);
  localparam int NCB = $clog2(MAX_COLUMNS + 1);
  localparam int NRB = $clog2(MAX_ROWS + 1);

  // Signed width that holds both an 18-bit query and the clamp limit.
  localparam int LIMB = (CB > RB) ? CB : RB;
  localparam int CQW  = 1 + ((LIMB + 8 > 17) ? LIMB + 8 : 17);

  // The grid is split into four banks by row and column parity.
  localparam int CHB_RAW = $clog2((MAX_COLUMNS + 1) / 2);
  localparam int RHB_RAW = $clog2((MAX_ROWS + 1) / 2);
  localparam int CHB = (CHB_RAW > 0) ? CHB_RAW : 1;
  localparam int RHB = (RHB_RAW > 0) ? RHB_RAW : 1;
  localparam int BANK_AW    = CHB + RHB;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int BANK_W     = 64;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MAP  = 1'b1;

  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  typedef struct packed {
    logic               op;
    logic [7:0]         load_column;
    logic [7:0]         load_row;
    logic [31:0]        load_x_value;
    logic [31:0]        load_y_value;
    logic [CB-1:0]      ul;
    logic [RB-1:0]      vl;
    logic [7:0]         du;
    logic [7:0]         dv;
    logic               clamped;
  } item_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [FIFO_CW-1:0] fill;
  } fifo_status_t;

endpackage

### rtl/core/gbcm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the grid banks.
module gbcm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/gbcm_front.sv
// Front end: classifies an incoming transaction and, for a query, clamps the
// position to the grid and splits it into cell and fraction. Uses gbcm_pkg.
module gbcm_front import gbcm_pkg::*; (
  input  logic               [8:0]  grid_width,
  input  logic               [8:0]  grid_height,
  input  logic                      operation,
  input  logic               [7:0]  load_column,
  input  logic               [7:0]  load_row,
  input  logic signed        [31:0] load_x_value,
  input  logic signed        [31:0] load_y_value,
  input  logic signed        [17:0] query_x,
  input  logic signed        [17:0] query_y,
  output item_t                     item
);

  logic [NCB-1:0]        nx;
  logic [NRB-1:0]        ny;
  logic [CB-1:0]         ux_max;
  logic [RB-1:0]         vy_max;
  logic signed [CQW-1:0] qx;
  logic signed [CQW-1:0] qy;
  logic signed [CQW-1:0] tx;
  logic signed [CQW-1:0] ty;
  logic [CB+7:0]         cx;
  logic [RB+7:0]         cy;
  logic                  fx;
  logic                  fy;

  always_comb begin
    if (grid_width == 9'd0) begin
      nx = NCB'(1);
    end else if (32'(grid_width) > MAX_COLUMNS) begin
      nx = NCB'(MAX_COLUMNS);
    end else begin
      nx = NCB'(grid_width);
    end
    if (grid_height == 9'd0) begin
      ny = NRB'(1);
    end else if (32'(grid_height) > MAX_ROWS) begin
      ny = NRB'(MAX_ROWS);
    end else begin
      ny = NRB'(grid_height);
    end

    ux_max = CB'(nx - NCB'(1));
    vy_max = RB'(ny - NRB'(1));
    tx = signed'(CQW'({ux_max, 8'h00}));
    ty = signed'(CQW'({vy_max, 8'h00}));
    qx = CQW'(query_x);
    qy = CQW'(query_y);

    if (qx < 0) begin
      cx = '0;
      fx = 1'b1;
    end else if (qx > tx) begin
      cx = {ux_max, 8'h00};
      fx = 1'b1;
    end else begin
      cx = (CB+8)'(qx);
      fx = 1'b0;
    end
    if (qy < 0) begin
      cy = '0;
      fy = 1'b1;
    end else if (qy > ty) begin
      cy = {vy_max, 8'h00};
      fy = 1'b1;
    end else begin
      cy = (RB+8)'(qy);
      fy = 1'b0;
    end

    item.op           = operation;
    item.load_column  = load_column;
    item.load_row     = load_row;
    item.load_x_value = load_x_value;
    item.load_y_value = load_y_value;
    item.ul           = cx[CB+7:8];
    item.vl           = cy[RB+7:8];
    item.du           = cx[7:0];
    item.dv           = cy[7:0];
    item.clamped      = fx | fy;
  end

endmodule

### rtl/core/gbcm_fifo.sv
// Short transaction queue between the front end and the back end.
// Uses gbcm_pkg for the entry type and depth.
module gbcm_fifo import gbcm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  item_t        din,
  input  logic         pop,
  output item_t        dout,
  output fifo_status_t status
);

  item_t              entries [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wr_ptr;
  logic [FIFO_PW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == FIFO_DEPTH - 1) ? '0 : wr_ptr + FIFO_PW'(1);
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == FIFO_DEPTH - 1) ? '0 : rd_ptr + FIFO_PW'(1);
      end
      if (push && !pop) begin
        count <= count + FIFO_CW'(1);
      end else if (pop && !push) begin
        count <= count - FIFO_CW'(1);
      end
    end
  end

  assign dout         = entries[rd_ptr];
  assign status.full  = (count == FIFO_CW'(FIFO_DEPTH));
  assign status.empty = (count == '0);
  assign status.fill  = count;

endmodule

### rtl/core/gbcm_back.sv
// Back end: writes grid entries, reads the four corners from parity banks and
// blends them through a multiply and add pipeline. Uses gbcm_pkg, gbcm_ram.
module gbcm_back import gbcm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               avail,
  input  item_t              item,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] mapped_x,
  output logic signed [31:0] mapped_y,
  output logic               out_of_range
);

  logic               en;
  logic [3:0]         bank_we;
  logic [BANK_AW-1:0] waddr;
  logic [BANK_AW-1:0] raddr [4];
  logic [63:0]        rdata [4];
  logic [CB-1:0]      lcol;
  logic [RB-1:0]      lrow;
  logic               load_ok;

  // Issue stage registers.
  logic               v1;
  logic               ul0;
  logic               vl0;
  logic               zu;
  logic               zv;
  logic               flag1;
  logic [16:0]        w1 [4];

  // Product stage registers.
  logic               v2;
  logic               flag2;
  logic signed [49:0] px [4];
  logic signed [49:0] py [4];

  // Pair sum stage registers.
  logic               v3;
  logic               flag3;
  logic signed [50:0] sxa;
  logic signed [50:0] sxb;
  logic signed [50:0] sya;
  logic signed [50:0] syb;

  logic signed [31:0] cxv [4];
  logic signed [31:0] cyv [4];
  logic signed [51:0] sx;
  logic signed [51:0] sy;

  assign en  = !(result_valid && result_stall);
  assign pop = en && avail;

  always_comb begin
    logic       cpar;
    logic       rpar;
    logic [CB:0] csum;
    logic [RB:0] rsum;
    lcol    = CB'(item.load_column);
    lrow    = RB'(item.load_row);
    load_ok = (32'(item.load_column) < MAX_COLUMNS) && (32'(item.load_row) < MAX_ROWS);
    waddr   = {RHB'(lrow >> 1), CHB'(lcol >> 1)};
    for (int b = 0; b < 4; b++) begin
      cpar = b[0];
      rpar = b[1];
      // Each bank holds the even or odd neighbor of the cell along each axis.
      csum = (CB+1)'(item.ul) + (CB+1)'(cpar != item.ul[0]);
      rsum = (RB+1)'(item.vl) + (RB+1)'(rpar != item.vl[0]);
      raddr[b]   = {RHB'(rsum >> 1), CHB'(csum >> 1)};
      bank_we[b] = pop && (item.op == OP_LOAD) && load_ok &&
                   (lcol[0] == cpar) && (lrow[0] == rpar);
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    gbcm_ram #(
      .WIDTH (BANK_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we[g]),
      .waddr (waddr),
      .wdata ({item.load_x_value, item.load_y_value}),
      .re    (en),
      .raddr (raddr[g]),
      .rdata (rdata[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ul0   <= item.ul[0];
      vl0   <= item.vl[0];
      zu    <= (item.du == 8'd0);
      zv    <= (item.dv == 8'd0);
      flag1 <= item.clamped;
      w1[0] <= (17'd256 - 17'(item.du)) * (17'd256 - 17'(item.dv));
      w1[1] <= 17'(item.du) * (17'd256 - 17'(item.dv));
      w1[2] <= (17'd256 - 17'(item.du)) * 17'(item.dv);
      w1[3] <= 17'(item.du) * 17'(item.dv);
    end
  end

  // Corners with zero weight may lie past the loaded grid, so they are forced
  // to zero rather than trusted.
  always_comb begin
    logic [1:0] idx;
    for (int k = 0; k < 4; k++) begin
      idx    = {vl0 ^ k[1], ul0 ^ k[0]};
      cxv[k] = rdata[idx][63:32];
      cyv[k] = rdata[idx][31:0];
      if ((k[0] && zu) || (k[1] && zv)) begin
        cxv[k] = '0;
        cyv[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flag2 <= flag1;
      for (int k = 0; k < 4; k++) begin
        px[k] <= 50'(cxv[k]) * 50'(signed'({1'b0, w1[k]}));
        py[k] <= 50'(cyv[k]) * 50'(signed'({1'b0, w1[k]}));
      end
      flag3 <= flag2;
      sxa   <= 51'(px[0]) + 51'(px[1]);
      sxb   <= 51'(px[2]) + 51'(px[3]);
      sya   <= 51'(py[0]) + 51'(py[1]);
      syb   <= 51'(py[2]) + 51'(py[3]);
    end
  end

  always_comb begin
    sx = 52'(sxa) + 52'(sxb) + 52'sd32768;
    sy = 52'(sya) + 52'(syb) + 52'sd32768;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mapped_x     <= sx[47:16];
      mapped_y     <= sy[47:16];
      out_of_range <= flag3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      v1           <= pop && (item.op == OP_MAP);
      v2           <= v1;
      v3           <= v2;
      result_valid <= v3;
    end
  end

endmodule

### rtl/core/grid_bilinear_coordinate_map_core.sv
// Top level of the grid bilinear coordinate map: configuration registers,
// front end, transaction queue and back end. Uses gbcm_pkg and all gbcm_* modules.
//
// Usage:
//   The item channel (item_valid, item_stall) takes one transaction per cycle while item_stall is low.
//   A load transaction writes one x/y grid entry and gives no result; a map
//   transaction gives one result on the result channel (result_valid,
//   result_stall) with the interpolated x and y and the out_of_range flag.
//   A map result passes through the queue and the issue, product, pair sum
//   and output registers; while the receiver does not stall, one transaction
//   per cycle is sustained, set by the four parity banks that deliver all four corners in one read.
//   Loads and queries take effect in accept order, so a query sees every load
//   accepted before it.
//   While the receiver stalls, the back-end pipeline holds and the front queue
//   of four entries keeps taking transactions; item_stall rises when it is full.
//   Reset empties the queue and pipeline and sets grid_width and grid_height
//   to 256. Grid contents are not cleared; entries must be loaded before use.
//   cfg_write with cfg_index and cfg_data writes a register.
module grid_bilinear_coordinate_map_core import gbcm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               operation,
  input  logic [7:0]         load_column,
  input  logic [7:0]         load_row,
  input  logic signed [31:0] load_x_value,
  input  logic signed [31:0] load_y_value,
  input  logic signed [17:0] query_x,
  input  logic signed [17:0] query_y,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] mapped_x,
  output logic signed [31:0] mapped_y,
  output logic               out_of_range
);

  logic [8:0]   grid_width;
  logic [8:0]   grid_height;
  item_t        front_item;
  item_t        queue_item;
  fifo_status_t fstat;
  logic         push;
  logic         pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 9'd256;
      grid_height <= 9'd256;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  gbcm_front u_front (
    .grid_width   (grid_width),
    .grid_height  (grid_height),
    .operation    (operation),
    .load_column  (load_column),
    .load_row     (load_row),
    .load_x_value (load_x_value),
    .load_y_value (load_y_value),
    .query_x      (query_x),
    .query_y      (query_y),
    .item         (front_item)
  );

  assign item_stall = fstat.full;
  assign push       = item_valid && !item_stall;

  gbcm_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (front_item),
    .pop    (pop),
    .dout   (queue_item),
    .status (fstat)
  );

  gbcm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .avail        (!fstat.empty),
    .item         (queue_item),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .mapped_x     (mapped_x),
    .mapped_y     (mapped_y),
    .out_of_range (out_of_range)
  );

  // After reset the queue is empty and no result is pending.
  a_reset_clean: assert property (@(posedge clk) rst |=> !result_valid && !item_stall)
    else $error("result or stall pending after reset");

  // The queue never pops while empty.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !fstat.empty)
    else $error("queue popped while empty");

  // A full queue that is not drained stays full on the next cycle.
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (fstat.full && !pop) |=> fstat.full)
    else $error("queue lost an entry");

endmodule

### test/grid_bilinear_coordinate_map_core_tb.sv
// Self-checking testbench for grid_bilinear_coordinate_map_core: loads grids, maps points
// and compares each result against an internal bilinear predictor. Depends on gbcm_pkg.
module grid_bilinear_coordinate_map_core_tb;
  import gbcm_pkg::*;

  typedef struct {
    logic        op;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [31:0] xv;
    logic [31:0] yv;
    logic [17:0] qx;
    logic [17:0] qy;
  } grid_item_t;

  typedef struct {
    logic [31:0] mx;
    logic [31:0] my;
    logic        oor;
  } mapped_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [8:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic operation = 1'b0;
  logic [7:0] load_column = '0;
  logic [7:0] load_row = '0;
  logic signed [31:0] load_x_value = '0;
  logic signed [31:0] load_y_value = '0;
  logic signed [17:0] query_x = '0;
  logic signed [17:0] query_y = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [31:0] mapped_x;
  logic signed [31:0] mapped_y;
  logic out_of_range;

  grid_bilinear_coordinate_map_core dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // Predictor state.
  logic [31:0] x_table [0:MAX_COLUMNS*MAX_ROWS-1];
  logic [31:0] y_table [0:MAX_COLUMNS*MAX_ROWS-1];
  bit loaded [0:MAX_COLUMNS*MAX_ROWS-1];
  int unsigned width_reg = 256, height_reg = 256;

  grid_item_t pending_items[$];
  mapped_point_t expected_points[$];
  int errors = 0;
  int results_seen = 0;
  int clamped_seen = 0;
  longint cycle_count = 0;
  bit idle_enabled = 1'b1;
  bit sender_hold = 1'b0;
  int send_gap = 0, stall_left = 0;

  function automatic int unsigned eff_size(int unsigned r, int unsigned m);
    if (r == 0) return 1;
    if (r > m) return m;
    return r;
  endfunction

  function automatic logic [31:0] blend_corners(logic [31:0] a, logic [31:0] b,
      logic [31:0] c, logic [31:0] d, longint wa, longint wb, longint wc, longint wd);
    longint s;
    s = longint'($signed(a)) * wa + longint'($signed(b)) * wb
      + longint'($signed(c)) * wc + longint'($signed(d)) * wd;
    s = (s + 32768) >>> 16;
    return s[31:0];
  endfunction

  // Applies one accepted transaction to the predictor.
  function automatic void predict_item(grid_item_t it);
    int unsigned nx, ny, ul, vl, ur, vr, du, dv;
    longint qx, qy, topx, topy;
    bit flag;
    mapped_point_t p;
    if (it.op == OP_LOAD) begin
      x_table[it.row*MAX_COLUMNS + it.col] = it.xv;
      y_table[it.row*MAX_COLUMNS + it.col] = it.yv;
      loaded[it.row*MAX_COLUMNS + it.col] = 1'b1;
      return;
    end
    nx = eff_size(width_reg, MAX_COLUMNS);
    ny = eff_size(height_reg, MAX_ROWS);
    qx = longint'($signed(it.qx));
    qy = longint'($signed(it.qy));
    topx = (nx - 1) * 256;
    topy = (ny - 1) * 256;
    flag = 1'b0;
    if (qx < 0) begin qx = 0; flag = 1'b1; end
    else if (qx > topx) begin qx = topx; flag = 1'b1; end
    if (qy < 0) begin qy = 0; flag = 1'b1; end
    else if (qy > topy) begin qy = topy; flag = 1'b1; end
    ul = qx >> 8; du = qx & 255;
    vl = qy >> 8; dv = qy & 255;
    ur = (ul + 1 < nx) ? ul + 1 : nx - 1;
    vr = (vl + 1 < ny) ? vl + 1 : ny - 1;
    p.mx = blend_corners(x_table[vl*MAX_COLUMNS+ul], x_table[vl*MAX_COLUMNS+ur],
        x_table[vr*MAX_COLUMNS+ul], x_table[vr*MAX_COLUMNS+ur],
        (256-du)*(256-dv), du*(256-dv), (256-du)*dv, du*dv);
    p.my = blend_corners(y_table[vl*MAX_COLUMNS+ul], y_table[vl*MAX_COLUMNS+ur],
        y_table[vr*MAX_COLUMNS+ul], y_table[vr*MAX_COLUMNS+ur],
        (256-du)*(256-dv), du*(256-dv), (256-du)*dv, du*dv);
    p.oor = flag;
    expected_points.push_back(p);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    errors++;
  endtask

  // Driver: presents the head of the queue; the predictor follows accepted items.
  always @(negedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) begin
        // Acceptance takes place at the coming rising edge.
      end
    end
  end

  bit drive_busy = 1'b0;
  grid_item_t cur_item;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && item_valid && !item_stall) begin
      predict_item(cur_item);
      drive_busy = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (!drive_busy) begin
        if (send_gap > 0) send_gap--;
        if (send_gap == 0 && !sender_hold && pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          drive_busy = 1'b1;
          operation <= cur_item.op;
          load_column <= cur_item.col;
          load_row <= cur_item.row;
          load_x_value <= cur_item.xv;
          load_y_value <= cur_item.yv;
          query_x <= cur_item.qx;
          query_y <= cur_item.qy;
          item_valid <= 1'b1;
          if (idle_enabled && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 13);
        end else begin
          item_valid <= 1'b0;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (idle_enabled && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    mapped_point_t w;
    if (!rst && result_valid && !result_stall) begin
      if (expected_points.size() == 0) begin
        $display("unexpected result at cycle %0d", cycle_count);
        errors++;
      end else begin
        w = expected_points.pop_front();
        results_seen++;
        if (w.oor) clamped_seen++;
        if (mapped_x !== w.mx) report_mismatch("mapped_x", mapped_x, w.mx);
        if (mapped_y !== w.my) report_mismatch("mapped_y", mapped_y, w.my);
        if (out_of_range !== w.oor)
          report_mismatch("out_of_range", 32'(out_of_range), 32'(w.oor));
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > 400000) begin
      $display("timeout with %0d results outstanding", expected_points.size());
      $display("grid_bilinear_coordinate_map_core_tb: FAIL");
      $finish;
    end
  end

  function automatic grid_item_t load_item(int c, int r, logic [31:0] xv, logic [31:0] yv);
    grid_item_t it;
    it.op = OP_LOAD; it.col = 8'(c); it.row = 8'(r); it.xv = xv; it.yv = yv;
    it.qx = 18'($urandom); it.qy = 18'($urandom);
    return it;
  endfunction

  function automatic grid_item_t map_item(logic [17:0] qx, logic [17:0] qy);
    grid_item_t it;
    it.op = OP_MAP; it.col = 8'($urandom); it.row = 8'($urandom); it.xv = $urandom;
    it.yv = $urandom; it.qx = qx; it.qy = qy;
    return it;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Picks a query coordinate from extreme, negative, edge, beyond-edge and in-range values.
  function automatic logic [17:0] rand_query(int unsigned n);
    case ($urandom_range(0, 7))
      0: return 18'h20000;
      1: return 18'h1FFFF;
      2: return 18'(-int'($urandom_range(1, 600)));
      3: return 18'((n - 1) * 256 + $urandom_range(0, 600));
      4: return 18'((n - 1) * 256);
      default: return 18'($urandom_range(0, (n - 1) * 256));
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || drive_busy || expected_points.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_size(logic idx, int unsigned v);
    @(negedge clk);
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= 9'(v);
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_GRID_WIDTH) width_reg = v; else height_reg = v;
  endtask

  // Loads the used block fully, then mixes reloads with random queries.
  task automatic run_phase(int unsigned wr, int unsigned hr, int n_items);
    int unsigned nx, ny;
    write_size(CFG_GRID_WIDTH, wr);
    write_size(CFG_GRID_HEIGHT, hr);
    nx = eff_size(wr, MAX_COLUMNS);
    ny = eff_size(hr, MAX_ROWS);
    for (int r = 0; r < ny; r++)
      for (int c = 0; c < nx; c++)
        if (!loaded[r*MAX_COLUMNS+c] || (nx * ny < 40))
          pending_items.push_back(load_item(c, r, rand_value(), rand_value()));
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 4) == 0)
        pending_items.push_back(load_item($urandom_range(0, 255), $urandom_range(0, 255),
            rand_value(), rand_value()));
      else
        pending_items.push_back(map_item(rand_query(nx), rand_query(ny)));
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed: small grid with extreme values, corners, edges and out-of-range points.
    write_size(CFG_GRID_WIDTH, 2);
    write_size(CFG_GRID_HEIGHT, 2);
    pending_items.push_back(load_item(0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
    pending_items.push_back(load_item(1, 0, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_items.push_back(load_item(0, 1, 32'h0001_0000, 32'hFFFF_0000));
    pending_items.push_back(load_item(1, 1, 32'hFFFF_FFFF, 32'h0000_0001));
    pending_items.push_back(map_item(0, 0));
    pending_items.push_back(map_item(256, 256));
    pending_items.push_back(map_item(128, 128));
    pending_items.push_back(map_item(255, 1));
    pending_items.push_back(map_item(18'h20000, 18'h1FFFF));
    pending_items.push_back(map_item(18'h1FFFF, 18'h20000));
    pending_items.push_back(map_item(256, 18'h3FFFF));
    pending_items.push_back(map_item(18'h3FFFF, 256));
    pending_items.push_back(map_item(257, 100));
    wait_drained();
    // Zero size acts as one; an oversize register acts as the maximum.
    run_phase(0, 0, 12);
    run_phase(9'h1FF, 1, 40);
    run_phase(1, 300, 40);
    run_phase(7, 5, 100);
    // Hold the sender until every result has come back.
    sender_hold = 1'b1;
    wait_drained();
    sender_hold = 1'b0;
    run_phase(16, 16, 100);
    idle_enabled = 1'b0;
    run_phase(3, 11, 100);
    $display("ran %0d map results (%0d clamped) over several grid sizes", results_seen,
        clamped_seen);
    if (errors == 0)
      $display("grid_bilinear_coordinate_map_core_tb: PASS");
    else
      $display("grid_bilinear_coordinate_map_core_tb: FAIL");
    $finish;
  end
endmodule

### filelist.f
rtl/core/gbcm_pkg.sv
rtl/core/gbcm_ram.sv
rtl/core/gbcm_front.sv
rtl/core/gbcm_fifo.sv
rtl/core/gbcm_back.sv
rtl/core/grid_bilinear_coordinate_map_core.sv
test/grid_bilinear_coordinate_map_core_tb.sv
